// ----- sv/wpps_pkg.sv -----
// wpps_pkg: shared types and constants for the w-plane phase screen sampler
// no dependencies; used by every module of the block
package wpps_pkg;

  // register indexes on the configuration port (word address)
  localparam logic [1:0] REG_PLANE_INDEX   = 2'd0;
  localparam logic [1:0] REG_INV_W_SCALE   = 2'd1;
  localparam logic [1:0] REG_SAMPLING_STEP = 2'd2;

  // one in Q2.30 and pi/2 in Q2.30
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [19:0] plane_sq;
    logic [31:0] inv_w_scale;
    logic [31:0] sampling_step;
  } cfg_t;

  // per-sample control that rides along the pipeline
  typedef struct packed {
    logic        ok;
    logic        zero;
    logic [1:0]  quad;
    logic [19:0] idx;
    logic [15:0] taper;
  } side_t;

endpackage

// ----- sv/wpps_cfg.sv -----
// wpps_cfg: apb register bank for plane index, inverse w scale and sampling step
// depends on wpps_pkg
module wpps_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output wpps_pkg::cfg_t     cfg
);

  logic [9:0]  plane_r;
  logic [31:0] inv_r;
  logic [31:0] step_r;
  logic [19:0] plane_sq_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
      inv_r   <= '0;
      step_r  <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        wpps_pkg::REG_PLANE_INDEX:   plane_r <= pwdata[9:0];
        wpps_pkg::REG_INV_W_SCALE:   inv_r   <= pwdata;
        wpps_pkg::REG_SAMPLING_STEP: step_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // squared plane index, kept registered for the phase multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_sq_r <= '0;
    end else begin
      plane_sq_r <= 20'(plane_r) * 20'(plane_r);
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      wpps_pkg::REG_PLANE_INDEX:   prdata = {22'd0, plane_r};
      wpps_pkg::REG_INV_W_SCALE:   prdata = inv_r;
      wpps_pkg::REG_SAMPLING_STEP: prdata = step_r;
      default:                     prdata = '0;
    endcase
  end

  assign cfg.plane_sq      = plane_sq_r;
  assign cfg.inv_w_scale   = inv_r;
  assign cfg.sampling_step = step_r;

endmodule

// ----- sv/wpps_sqrt.sv -----
// wpps_sqrt: pipelined 64-bit integer square root, one result bit per stage
// depends on wpps_pkg for the sideband type
module wpps_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [63:0]        in_rad,
  input  wpps_pkg::side_t    in_side,
  output logic               out_vld,
  output logic [31:0]        out_root,
  output wpps_pkg::side_t    out_side
);

  localparam int unsigned STEPS = 32;

  logic [63:0]     rem_r  [STEPS];
  logic [63:0]     root_r [STEPS];
  logic            vld_r  [STEPS];
  wpps_pkg::side_t side_r [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam logic [63:0] BITV = 64'd1 << (2 * (STEPS - 1 - g));
    logic [63:0]     rem_in;
    logic [63:0]     root_in;
    logic [63:0]     trial;
    logic            vld_in;
    wpps_pkg::side_t side_in;

    if (g == 0) begin : g_first
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign vld_in  = in_vld;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign vld_in  = vld_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign trial = root_in + BITV;

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (adv) begin
        vld_r[g] <= vld_in;
      end
    end

    // restoring step: try the next root bit
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_in >= trial) begin
          rem_r[g]  <= rem_in - trial;
          root_r[g] <= (root_in >> 1) + BITV;
        end else begin
          rem_r[g]  <= rem_in;
          root_r[g] <= root_in >> 1;
        end
        side_r[g] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_root = root_r[STEPS-1][31:0];
  assign out_side = side_r[STEPS-1];

endmodule

// ----- sv/wpps_sincos.sv -----
// wpps_sincos: pipelined sine and cosine of a quarter-turn angle, Taylor series in Q2.30
// depends on wpps_pkg for constants and the sideband type
module wpps_sincos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic [29:0]        in_frac,
  input  wpps_pkg::side_t    in_side,
  output logic               out_vld,
  output logic [30:0]        out_sin,
  output logic [30:0]        out_cos,
  output wpps_pkg::side_t    out_side
);

  localparam int unsigned NST       = 8;
  localparam int unsigned NDIV      = 8;
  localparam int unsigned RCP_SHIFT = 35;

  // divisors of t^2: 72, 90, 42, 56, 20, 30, 6, 12
  function automatic int unsigned divisor(input int unsigned idx);
    int unsigned d;
    case (idx)
      0:       d = 72;
      1:       d = 90;
      2:       d = 42;
      3:       d = 56;
      4:       d = 20;
      5:       d = 30;
      6:       d = 6;
      default: d = 12;
    endcase
    return d;
  endfunction

  function automatic logic [30:0] one_minus(input logic [33:0] v);
    logic [33:0] one;
    one = 34'(wpps_pkg::Q30_ONE);
    return (v >= one) ? 31'd0 : 31'(one - v);
  endfunction

  function automatic logic [33:0] mulq(input logic [31:0] a, input logic [30:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return p[63:30];
  endfunction

  logic            vld_r  [NST];
  wpps_pkg::side_t side_r [NST];

  // valid and sideband shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      for (int i = 1; i < NST; i++) side_r[i] <= side_r[i-1];
    end
  end

  // stage 1: angle in radians
  logic [30:0] theta1_r;
  logic [60:0] theta_prod;
  assign theta_prod = 61'(in_frac) * 61'(wpps_pkg::HALF_PI_Q30);
  always_ff @(posedge clk) begin
    if (adv) theta1_r <= theta_prod[60:30];
  end

  // stage 2: angle squared
  logic [30:0] theta2_r;
  logic [31:0] t2_2_r;
  logic [61:0] sq_prod;
  assign sq_prod = 62'(theta1_r) * 62'(theta1_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      theta2_r <= theta1_r;
      t2_2_r   <= sq_prod[61:30];
    end
  end

  // stage 3: reciprocal products for the constant divisions
  logic [64:0] rcp3_r [NDIV];
  logic [30:0] theta3_r;
  logic [31:0] t2_3_r;
  for (genvar g = 0; g < NDIV; g++) begin : g_rcp
    localparam logic [32:0] RCP = 33'((64'd1 << RCP_SHIFT) / 64'(divisor(g)));
    always_ff @(posedge clk) begin
      if (adv) rcp3_r[g] <= 65'(t2_2_r) * 65'(RCP);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      theta3_r <= theta2_r;
      t2_3_r   <= t2_2_r;
    end
  end

  // stage 4: correct each estimate by at most one, start both series
  logic [29:0] quo [NDIV];
  for (genvar g = 0; g < NDIV; g++) begin : g_fix
    logic [29:0] est;
    logic [39:0] diff;
    assign est  = rcp3_r[g][64:35];
    assign diff = 40'(t2_3_r) - 40'(est) * 40'(divisor(g));
    assign quo[g] = (diff >= 40'(divisor(g))) ? est + 30'd1 : est;
  end

  logic [30:0] a4_r, b4_r, theta4_r, half4_r;
  logic [29:0] q42_4_r, q56_4_r, q20_4_r, q30_4_r, q6_4_r, q12_4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a4_r     <= one_minus(34'(quo[0]));
      b4_r     <= one_minus(34'(quo[1]));
      q42_4_r  <= quo[2];
      q56_4_r  <= quo[3];
      q20_4_r  <= quo[4];
      q30_4_r  <= quo[5];
      q6_4_r   <= quo[6];
      q12_4_r  <= quo[7];
      theta4_r <= theta3_r;
      half4_r  <= t2_3_r[31:1];
    end
  end

  // stage 5: second nesting level
  logic [30:0] a5_r, b5_r, theta5_r, half5_r;
  logic [29:0] q20_5_r, q30_5_r, q6_5_r, q12_5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a5_r     <= one_minus(mulq(32'(q42_4_r), a4_r));
      b5_r     <= one_minus(mulq(32'(q56_4_r), b4_r));
      q20_5_r  <= q20_4_r;
      q30_5_r  <= q30_4_r;
      q6_5_r   <= q6_4_r;
      q12_5_r  <= q12_4_r;
      theta5_r <= theta4_r;
      half5_r  <= half4_r;
    end
  end

  // stage 6: third nesting level
  logic [30:0] a6_r, b6_r, theta6_r, half6_r;
  logic [29:0] q6_6_r, q12_6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a6_r     <= one_minus(mulq(32'(q20_5_r), a5_r));
      b6_r     <= one_minus(mulq(32'(q30_5_r), b5_r));
      q6_6_r   <= q6_5_r;
      q12_6_r  <= q12_5_r;
      theta6_r <= theta5_r;
      half6_r  <= half5_r;
    end
  end

  // stage 7: fourth nesting level
  logic [30:0] a7_r, b7_r, theta7_r, half7_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a7_r     <= one_minus(mulq(32'(q6_6_r), a6_r));
      b7_r     <= one_minus(mulq(32'(q12_6_r), b6_r));
      theta7_r <= theta6_r;
      half7_r  <= half6_r;
    end
  end

  // stage 8: final products, sine clamped to one
  logic [33:0] sin_raw;
  logic [30:0] sin8_r, cos8_r;
  assign sin_raw = mulq(32'(theta7_r), a7_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      sin8_r <= (sin_raw > 34'(wpps_pkg::Q30_ONE)) ? wpps_pkg::Q30_ONE : sin_raw[30:0];
      cos8_r <= one_minus(mulq(32'(half7_r), b7_r));
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_side = side_r[NST-1];
  assign out_sin  = sin8_r;
  assign out_cos  = cos8_r;

endmodule

// ----- sv/w_plane_phase_screen_sample.sv -----
// One w-plane phase screen sample per cycle while results are taken. A request carries a
// signed column and row offset and two taper weights; the result carries the wrapped screen
// address and taper times cos and sin of the w phase, or written = 0 outside the unit circle
// or the inner window. The datapath is a 48-stage pipeline (3 geometry stages, 32 square
// root stages, 4 phase stages, 8 sine/cosine stages, 1 output stage) and one request is
// taken every cycle. A result not taken freezes the whole pipeline, so throughput then
// follows the output side. The user must write registers only with the pipeline empty;
// the block itself does not enforce this.
// depends on wpps_pkg, wpps_cfg, wpps_sqrt and wpps_sincos
module w_plane_phase_screen_sample #(
  parameter int SCREEN_SIZE = 1024,
  parameter int INNER       = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  // apb configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [7:0]  in_column_offset,
  input  logic signed [7:0]  in_row_offset,
  input  logic [15:0]        in_taper_x,
  input  logic [15:0]        in_taper_y,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [19:0]        out_screen_index,
  output logic signed [15:0] out_real_part,
  output logic signed [15:0] out_imag_part,
  output logic               out_written
);

  localparam int HALF_INNER = INNER / 2;

  wpps_pkg::cfg_t cfg;
  logic           adv;

  wpps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // whole pipeline moves unless a result is waiting
  assign adv      = out_ready | ~out_valid;
  assign in_ready = adv;

  // stage 1: window check, direction cosines, address and taper
  logic signed [31:0] col_s, row_s;
  logic [7:0]         acol, arow;
  logic [31:0]        cw, rw, idx_full;
  logic [31:0]        taper_prod;
  logic               win_ok;
  wpps_pkg::side_t    side1_c;

  assign col_s  = 32'(in_column_offset);
  assign row_s  = 32'(in_row_offset);
  assign win_ok = (col_s >= -HALF_INNER) && (col_s <= HALF_INNER - 1) &&
                  (row_s >= -HALF_INNER) && (row_s <= HALF_INNER - 1);
  assign acol   = in_column_offset[7] ? 8'(-col_s) : in_column_offset;
  assign arow   = in_row_offset[7]    ? 8'(-row_s) : in_row_offset;
  assign cw     = col_s + (in_column_offset[7] ? 32'(SCREEN_SIZE) : 32'd0);
  assign rw     = row_s + (in_row_offset[7]    ? 32'(SCREEN_SIZE) : 32'd0);
  assign idx_full   = 32'(rw * 32'(SCREEN_SIZE)) + cw;
  assign taper_prod = 32'(in_taper_x) * 32'(in_taper_y);

  always_comb begin
    side1_c.ok    = win_ok;
    side1_c.zero  = 1'b0;
    side1_c.quad  = 2'd0;
    side1_c.idx   = idx_full[19:0];
    side1_c.taper = taper_prod[31:16];
  end

  logic            v1_r;
  logic [39:0]     l1_r, m1_r;
  wpps_pkg::side_t side1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r    <= 40'(cfg.sampling_step) * 40'(acol);
      m1_r    <= 40'(cfg.sampling_step) * 40'(arow);
      side1_r <= side1_c;
    end
  end

  // stage 2: squares, reject a cosine at or above one
  logic            v2_r;
  logic [63:0]     lsq2_r, msq2_r;
  wpps_pkg::side_t side2_r, side2_nxt;
  always_comb begin
    side2_nxt    = side1_r;
    side2_nxt.ok = side1_r.ok && (l1_r[39:32] == 8'd0) && (m1_r[39:32] == 8'd0);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      lsq2_r  <= 64'(l1_r[31:0]) * 64'(l1_r[31:0]);
      msq2_r  <= 64'(m1_r[31:0]) * 64'(m1_r[31:0]);
      side2_r <= side2_nxt;
    end
  end

  // stage 3: r squared and the radicand 1 - r squared
  logic [64:0]     rsq;
  logic            v3_r;
  logic [63:0]     rad3_r;
  wpps_pkg::side_t side3_r, side3_nxt;
  assign rsq = 65'(lsq2_r) + 65'(msq2_r);
  always_comb begin
    side3_nxt      = side2_r;
    side3_nxt.ok   = side2_r.ok && !rsq[64];
    side3_nxt.zero = (rsq[63:0] == 64'd0);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rad3_r  <= 64'd0 - rsq[63:0];
      side3_r <= side3_nxt;
    end
  end

  // square root
  logic            vsq;
  logic [31:0]     root;
  wpps_pkg::side_t side_sq;
  wpps_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v3_r),
    .in_rad   (rad3_r),
    .in_side  (side3_r),
    .out_vld  (vsq),
    .out_root (root),
    .out_side (side_sq)
  );

  // stage 4: t = 1 - sqrt(1 - r squared)
  logic [32:0]     t_full;
  logic            v4_r;
  logic [31:0]     t4_r;
  wpps_pkg::side_t side4_r;
  assign t_full = 33'h1_0000_0000 - 33'(root);
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= vsq;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t4_r    <= side_sq.zero ? 32'd0 : t_full[31:0];
      side4_r <= side_sq;
    end
  end

  // stage 5: scale by the inverse w scale
  logic            v5_r;
  logic [63:0]     u5_r;
  wpps_pkg::side_t side5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      u5_r    <= 64'(cfg.inv_w_scale) * 64'(t4_r);
      side5_r <= side4_r;
    end
  end

  // stage 6: plane index squared times u, split in two partial products
  logic [51:0]     phi_prod, plo_prod;
  logic            v6_r;
  logic [31:0]     phi6_r;
  logic [51:0]     plo6_r;
  wpps_pkg::side_t side6_r;
  assign phi_prod = 52'(cfg.plane_sq) * 52'(u5_r[63:32]);
  assign plo_prod = 52'(cfg.plane_sq) * 52'(u5_r[31:0]);
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      phi6_r  <= phi_prod[31:0];
      plo6_r  <= plo_prod;
      side6_r <= side5_r;
    end
  end

  // stage 7: fractional turn, negated phase split into quadrant and angle
  logic [31:0]     frac, phase;
  logic            v7_r;
  logic [29:0]     x7_r;
  wpps_pkg::side_t side7_r, side7_nxt;
  assign frac  = phi6_r + 32'(plo6_r[51:32]);
  assign phase = 32'd0 - frac;
  always_comb begin
    side7_nxt      = side6_r;
    side7_nxt.quad = phase[31:30];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (adv) v7_r <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      x7_r    <= phase[29:0];
      side7_r <= side7_nxt;
    end
  end

  // sine and cosine
  logic            vsc;
  logic [30:0]     sin_q, cos_q;
  wpps_pkg::side_t side_sc;
  wpps_sincos u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v7_r),
    .in_frac  (x7_r),
    .in_side  (side7_r),
    .out_vld  (vsc),
    .out_sin  (sin_q),
    .out_cos  (cos_q),
    .out_side (side_sc)
  );

  // output stage: quadrant fold, taper scaling, saturation
  logic [30:0] cmag, smag;
  logic        cneg, sneg;
  logic [46:0] cprod, sprod;
  logic [15:0] cpart, spart, csat, ssat;

  always_comb begin
    case (side_sc.quad)
      2'd0: begin
        cmag = cos_q; cneg = 1'b0; smag = sin_q; sneg = 1'b0;
      end
      2'd1: begin
        cmag = sin_q; cneg = 1'b1; smag = cos_q; sneg = 1'b0;
      end
      2'd2: begin
        cmag = cos_q; cneg = 1'b1; smag = sin_q; sneg = 1'b1;
      end
      default: begin
        cmag = sin_q; cneg = 1'b0; smag = cos_q; sneg = 1'b1;
      end
    endcase
  end

  assign cprod = 47'(side_sc.taper) * 47'(cmag);
  assign sprod = 47'(side_sc.taper) * 47'(smag);
  assign csat  = cprod[46:31] > 16'd32767 ? 16'd32767 : cprod[46:31];
  assign ssat  = sprod[46:31] > 16'd32767 ? 16'd32767 : sprod[46:31];
  assign cpart = cneg ? 16'd0 - csat : csat;
  assign spart = sneg ? 16'd0 - ssat : ssat;

  logic               out_vld_r;
  logic [19:0]        out_idx_r;
  logic signed [15:0] out_re_r, out_im_r;
  logic               out_wr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= vsc;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (side_sc.ok) begin
        out_idx_r <= side_sc.idx;
        out_re_r  <= cpart;
        out_im_r  <= spart;
        out_wr_r  <= 1'b1;
      end else begin
        out_idx_r <= '0;
        out_re_r  <= '0;
        out_im_r  <= '0;
        out_wr_r  <= 1'b0;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_screen_index = out_idx_r;
  assign out_real_part    = out_re_r;
  assign out_imag_part    = out_im_r;
  assign out_written      = out_wr_r;

endmodule

// ----- tb/sv/testbench.sv -----
// testbench for w_plane_phase_screen_sample: directed and random requests checked
// against a bit-exact predictor of the phase screen sample
// depends on wpps_pkg and the w_plane_phase_screen_sample rtl
`timescale 1ns / 100ps

module testbench;

  localparam int SCREEN_SIZE = 1024;
  localparam int INNER     = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [19:0]        screen_index;
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
    logic               written;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [7:0] in_column_offset = '0, in_row_offset = '0;
  logic [15:0] in_taper_x = '0, in_taper_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [19:0] out_screen_index;
  logic signed [15:0] out_real_part, out_imag_part;
  logic out_written;

  // local copy of the configuration registers
  logic [9:0]  plane_reg = '0;
  logic [31:0] inv_scale_reg = '0;
  logic [31:0] step_reg = '0;

  sample_t expected_samples[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  w_plane_phase_screen_sample #(.SCREEN_SIZE(SCREEN_SIZE), .INNER(INNER)) dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_column_offset, .in_row_offset, .in_taper_x, .in_taper_y,
    .out_valid, .out_ready, .out_screen_index, .out_real_part, .out_imag_part,
    .out_written
  );

  // q2.30 helpers
  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic logic [63:0] one_less(logic [63:0] v);
    return (v >= 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - v;
  endfunction

  function automatic logic [31:0] root64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [15:0] signed_part(logic [63:0] taper, logic [63:0] mag,
                                              logic neg);
    logic [63:0] p;
    p = (taper * mag) >> 31;
    if (p > 64'd32767) p = 64'd32767;
    return neg ? 16'(-p[15:0]) : p[15:0];
  endfunction

  // phase screen sample for one request under the current registers
  function automatic sample_t phase_screen_sample(logic signed [7:0] col,
      logic signed [7:0] row, logic [15:0] tx, logic [15:0] ty);
    sample_t r;
    logic [63:0] acol, arow, l, m, lsq, msq, rsq, root, t, u, k, x, theta;
    logic [63:0] t2, sa, ca, s, c, cmag, smag, taper;
    logic [31:0] frac, ph;
    logic [1:0] quad;
    logic cneg, sneg;
    int rw, cw;
    r = '0;
    if (col < -(INNER / 2) || col > INNER / 2 - 1 ||
        row < -(INNER / 2) || row > INNER / 2 - 1) return r;
    acol = (col < 0) ? 64'(-int'(col)) : 64'(col);
    arow = (row < 0) ? 64'(-int'(row)) : 64'(row);
    l = 64'(step_reg) * acol;
    m = 64'(step_reg) * arow;
    if (l >= 64'h1_0000_0000 || m >= 64'h1_0000_0000) return r;
    lsq = l * l;
    msq = m * m;
    if (lsq > ~msq) return r;
    rsq = lsq + msq;
    root = (rsq == 0) ? 64'h1_0000_0000 : 64'(root64(-rsq));
    t = 64'h1_0000_0000 - root;
    u = 64'(inv_scale_reg) * t;
    k = 64'(plane_reg) * 64'(plane_reg);
    frac = 32'((k * u) >> 32);
    ph = -frac;
    quad = ph[31:30];
    x = 64'(ph[29:0]);
    theta = (x * 64'd1686629713) >> 30;
    // taylor series in nested form
    t2 = mul_q30(theta, theta);
    sa = one_less(t2 / 72);
    sa = one_less(mul_q30(t2 / 42, sa));
    sa = one_less(mul_q30(t2 / 20, sa));
    sa = one_less(mul_q30(t2 / 6, sa));
    sa = mul_q30(theta, sa);
    s = (sa > 64'h4000_0000) ? 64'h4000_0000 : sa;
    ca = one_less(t2 / 90);
    ca = one_less(mul_q30(t2 / 56, ca));
    ca = one_less(mul_q30(t2 / 30, ca));
    ca = one_less(mul_q30(t2 / 12, ca));
    c = one_less(mul_q30(t2 >> 1, ca));
    case (quad)
      2'd0: begin cmag = c; cneg = 0; smag = s; sneg = 0; end
      2'd1: begin cmag = s; cneg = 1; smag = c; sneg = 0; end
      2'd2: begin cmag = c; cneg = 1; smag = s; sneg = 1; end
      default: begin cmag = s; cneg = 0; smag = c; sneg = 1; end
    endcase
    taper = (64'(tx) * 64'(ty)) >> 16;
    rw = (row >= 0) ? int'(row) : int'(row) + SCREEN_SIZE;
    cw = (col >= 0) ? int'(col) : int'(col) + SCREEN_SIZE;
    r.screen_index = 20'(rw * SCREEN_SIZE + cw);
    r.real_part = signed_part(taper, cmag, cneg);
    r.imag_part = signed_part(taper, smag, sneg);
    r.written = 1'b1;
    return r;
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_s = expected_samples.pop_front();
        if (out_screen_index !== exp_s.screen_index) begin
          $error("screen_index expected %0d got %0d", exp_s.screen_index, out_screen_index);
          errors++;
        end
        if (out_real_part !== exp_s.real_part) begin
          $error("real_part expected %0d got %0d", exp_s.real_part, out_real_part);
          errors++;
        end
        if (out_imag_part !== exp_s.imag_part) begin
          $error("imag_part expected %0d got %0d", exp_s.imag_part, out_imag_part);
          errors++;
        end
        if (out_written !== exp_s.written) begin
          $error("written expected %0d got %0d", exp_s.written, out_written);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {index, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (index)
      wpps_pkg::REG_PLANE_INDEX: plane_reg = value[9:0];
      wpps_pkg::REG_INV_W_SCALE: inv_scale_reg = value;
      wpps_pkg::REG_SAMPLING_STEP: step_reg = value;
      default: ;
    endcase
  endtask

  task automatic set_registers(logic [9:0] plane, logic [31:0] inv_scale,
                               logic [31:0] step);
    write_reg(wpps_pkg::REG_PLANE_INDEX, 32'(plane));
    write_reg(wpps_pkg::REG_INV_W_SCALE, inv_scale);
    write_reg(wpps_pkg::REG_SAMPLING_STEP, step);
  endtask

  // send one request; bursty gaps; valid stays up for a following request
  task automatic send_request(logic signed [7:0] col, logic signed [7:0] row,
                              logic [15:0] tx, logic [15:0] ty, bit gaps);
    int gap;
    gap = 0;
    if (gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = $urandom_range(0, 6);
      end
      burst_left--;
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_column_offset <= col; in_row_offset <= row;
    in_taper_x <= tx; in_taper_y <= ty;
    expected_samples.push_back(phase_screen_sample(col, row, tx, ty));
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid after the last request of a run
  task automatic stop_requests();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_requests();
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // corners of the window, unit circle edge, zero offsets, taper extremes
  task automatic test_directed();
    set_registers(10'd1023, 32'hFFFF_FFFF, 32'h0100_0000);
    send_request(0, 0, 16'hFFFF, 16'hFFFF, 0);
    send_request(127, 127, 16'hFFFF, 16'hFFFF, 0);
    send_request(-128, -128, 16'hFFFF, 16'hFFFF, 0);
    send_request(-128, 0, 16'hFFFF, 16'h0000, 0);
    send_request(127, -128, 16'h0000, 16'hFFFF, 0);
    send_request(0, -128, 16'h8000, 16'h8000, 0);
    send_request(-1, -1, 16'hFFFF, 16'hFFFF, 0);
    send_request(100, 0, 16'hAAAA, 16'h5555, 0);
    send_request(0, 100, 16'h5555, 16'hAAAA, 0);
    wait_drained();
    // step large enough that most pixels leave the unit circle
    set_registers(10'd7, 32'h1234_5678, 32'h0400_0000);
    send_request(63, 0, 16'hFFFF, 16'hFFFF, 0);
    send_request(64, 0, 16'hFFFF, 16'hFFFF, 0);
    send_request(45, 45, 16'hFFFF, 16'hFFFF, 0);
    send_request(46, 46, 16'hFFFF, 16'hFFFF, 0);
    send_request(-64, 1, 16'hFFFF, 16'hFFFF, 0);
    wait_drained();
    set_registers(10'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(0, 0, 16'hFFFF, 16'hFFFF, 0);
    send_request(1, 0, 16'hFFFF, 16'hFFFF, 0);
    send_request(0, -1, 16'hFFFF, 16'hFFFF, 0);
    wait_drained();
  endtask

  // random requests under several random register settings
  task automatic test_random_phases();
    logic [31:0] step;
    int cap;
    for (int phase = 0; phase < 13; phase++) begin
      case (phase % 4)
        0: step = $urandom_range(0, 32'h0200_0000);
        1: step = $urandom_range(0, 32'h0080_0000);
        2: step = $urandom();
        default: step = $urandom_range(32'h0100_0000, 32'h0300_0000);
      endcase
      set_registers(10'($urandom()), $urandom(), step);
      for (int i = 0; i < 150; i++) begin
        cap = (phase % 4 == 2) ? 1 : 127;
        if ($urandom_range(0, 9) < 8)
          send_request(8'($urandom_range(0, 2 * cap) - cap),
                       8'($urandom_range(0, 2 * cap) - cap),
                       16'($urandom()), 16'($urandom()), 1);
        else
          send_request(8'($urandom()), 8'($urandom()), 16'($urandom()),
                       16'($urandom()), 1);
        // hold off until the pipeline empties, now and then
        if (i == 75) begin
          stop_requests();
          while (expected_samples.size() != 0) @(negedge clk);
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_phases();
    wait_drained();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
